FILE: sv/bfc_pkg.sv
package bfc_pkg;

    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_MARKER    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_MARKER     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_LENGTH = 2'd2;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_START    = 3'd1,
        ERR_DECLARED = 3'd2,
        ERR_TOTAL    = 3'd3,
        ERR_PARITY   = 3'd4,
        ERR_STOP     = 3'd5
    } error_code_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_done;
        logic        frame_ok;
        error_code_t error_code;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  stop_marker;
        logic [15:0] expected_length;
    } cfg_t;

endpackage

FILE: sv/bfc_cfg_regs.sv
module bfc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [bfc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bfc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bfc_pkg::cfg_t                    cfg
);

    bfc_pkg::cfg_t cfg_reg;
    bfc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                bfc_pkg::CFG_START_MARKER:    cfg_next.start_marker    = cfg_data[7:0];
                bfc_pkg::CFG_STOP_MARKER:     cfg_next.stop_marker     = cfg_data[7:0];
                bfc_pkg::CFG_EXPECTED_LENGTH: cfg_next.expected_length = cfg_data[15:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/bfc_check.sv
module bfc_check (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bfc_pkg::cfg_t        cfg,
    input  bfc_pkg::in_item_t    item,
    input  logic                 step,
    output bfc_pkg::out_item_t   result
);

    logic [bfc_pkg::POS_W-1:0] pos_reg;
    logic [bfc_pkg::POS_W-1:0] pos_next;
    logic [7:0]                len_high_reg;
    logic [7:0]                len_high_next;
    logic [7:0]                parity_reg;
    logic [7:0]                parity_next;
    bfc_pkg::error_code_t      first_err_reg;
    bfc_pkg::error_code_t      first_err_next;

    logic [bfc_pkg::POS_W-1:0] parity_pos;
    logic [bfc_pkg::POS_W-1:0] stop_pos;
    bfc_pkg::error_code_t      err_found;
    bfc_pkg::error_code_t      err_byte;
    bfc_pkg::error_code_t      err_final;
    logic                      in_payload;

    assign parity_pos = {1'b0, cfg.expected_length} + bfc_pkg::POS_W'(3);
    assign stop_pos   = {1'b0, cfg.expected_length} + bfc_pkg::POS_W'(4);

    always_comb
    begin
        err_found     = bfc_pkg::ERR_NONE;
        in_payload    = 1'b0;
        len_high_next = len_high_reg;
        parity_next   = parity_reg;
        if (pos_reg == bfc_pkg::POS_W'(0))
        begin
            if (item.rx_byte != cfg.start_marker)
                err_found = bfc_pkg::ERR_START;
        end
        else if (pos_reg == bfc_pkg::POS_W'(1))
        begin
            len_high_next = item.rx_byte;
        end
        else if (pos_reg == bfc_pkg::POS_W'(2))
        begin
            if ({len_high_reg, item.rx_byte} != cfg.expected_length)
                err_found = bfc_pkg::ERR_DECLARED;
        end
        else if (pos_reg < parity_pos)
        begin
            in_payload  = 1'b1;
            parity_next = parity_reg ^ item.rx_byte;
        end
        else if (pos_reg == parity_pos)
        begin
            if (item.rx_byte != parity_reg)
                err_found = bfc_pkg::ERR_PARITY;
        end
        else if (pos_reg == stop_pos)
        begin
            if (item.rx_byte != cfg.stop_marker)
                err_found = bfc_pkg::ERR_STOP;
        end

        err_byte = (first_err_reg != bfc_pkg::ERR_NONE) ? first_err_reg : err_found;
        if (err_byte == bfc_pkg::ERR_NONE && pos_reg != stop_pos)
            err_final = bfc_pkg::ERR_TOTAL;
        else
            err_final = err_byte;

        if (item.end_of_frame)
        begin
            pos_next       = '0;
            len_high_next  = '0;
            parity_next    = '0;
            first_err_next = bfc_pkg::ERR_NONE;
        end
        else
        begin
            pos_next       = (pos_reg != bfc_pkg::POS_MAX) ? pos_reg + 1'b1 : pos_reg;
            first_err_next = err_byte;
        end
    end

    always_comb
    begin
        result.payload_byte  = in_payload ? item.rx_byte : 8'd0;
        result.payload_valid = in_payload;
        result.frame_done    = item.end_of_frame;
        result.frame_ok      = item.end_of_frame && (err_final == bfc_pkg::ERR_NONE);
        result.error_code    = item.end_of_frame ? err_final : bfc_pkg::ERR_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            len_high_reg  <= '0;
            parity_reg    <= '0;
            first_err_reg <= bfc_pkg::ERR_NONE;
        end
        else if (step)
        begin
            pos_reg       <= pos_next;
            len_high_reg  <= len_high_next;
            parity_reg    <= parity_next;
            first_err_reg <= first_err_next;
        end
    end

endmodule

FILE: sv/byte_frame_checker_xor_parity.sv
// channel | direction | handshake            | payload
// cfg     | in        | cfg_write_en         | cfg_index, cfg_data
// in      | in        | in_valid / in_ready  | in_item (rx_byte, end_of_frame)
// out     | out       | out_valid / out_ready| out_item (payload_byte .. error_code)
//
// One item per cycle sustained unless the output stalls; an item passes the input register, then the result register.
// Checking is a single pass of compares and an XOR between those two registers.
// Reset clears the config registers, the frame state and both valid flags, not the item registers.
// A stalled output holds its result; the input register keeps taking an item while
// the result register drains in the same cycle.
module byte_frame_checker_xor_parity (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [bfc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bfc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  bfc_pkg::in_item_t                in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output bfc_pkg::out_item_t               out_item
);

    bfc_pkg::cfg_t      cfg;
    bfc_pkg::in_item_t  in_item_reg;
    logic               in_valid_reg;
    logic               in_valid_next;
    bfc_pkg::out_item_t out_item_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    bfc_pkg::out_item_t result;
    logic               step;

    bfc_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    bfc_check u_check (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (in_item_reg),
        .step   (step),
        .result (result)
    );

    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_ready)
            in_valid_next = in_valid;
        if (step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_item_reg <= in_item;
        if (step)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
